// ===== design/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;
   localparam logic [1:0] CMD_READ   = 2'd3;

   localparam logic [7:0] CHAR_LF = 8'd10;
   localparam logic [7:0] CHAR_CR = 8'd13;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  char_code;
      logic [7:0]  attr;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [10:0] cursor_pos;
      logic [7:0]  cell_char;
      logic [7:0]  cell_attr;
   } rsp_type;

endpackage

// ===== design/tcw_ram.sv =====
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data
);

   logic [15:0] mem_ff [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/text_console_writer.sv =====
`timescale 1ns / 1ps

// Text console: COLUMNS x ROWS cells of {attribute, character} in one screen RAM,
// plus a cursor. A command is taken when start is high and busy is low; its single
// result appears on rsp_payload for exactly one cycle with rsp_strobe high, and the
// receiver cannot stall it. A delete at the home position is ignored.
// Clear walks every cell with one write a cycle, and a scroll copies each cell up one
// row through the single RAM read and write ports and zeroes the bottom row. After
// reset busy stays high while the screen RAM is zeroed.

module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tcw_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output tcw_pkg::rsp_type rsp_payload
);

   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_CLEAR  = 3'd2;
   localparam logic [2:0] ST_WRITE  = 3'd3;
   localparam logic [2:0] ST_SCROLL = 3'd4;
   localparam logic [2:0] ST_DRAIN  = 3'd5;
   localparam logic [2:0] ST_RESP   = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [7:0]    attr_ff, attr_in;
   logic          rd_hit_ff, rd_hit_in;
   logic          wpend_ff, wpend_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic          wr_zero_ff, wr_zero_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_type       rsp_payload_ff, rsp_payload_in;

   logic          accept;
   logic          newline;
   logic [AW-1:0] cur_pos;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [15:0]   ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [15:0]   ram_rd_data;

   assign accept  = start && (state_ff == ST_IDLE);
   assign newline = (req_payload.char_code == CHAR_LF) || (req_payload.char_code == CHAR_CR);
   assign cur_pos = AW'(32'(row_ff) * COLUMNS + 32'(col_ff));

   tcw_ram #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // RAM port steering
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cur_pos;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = AW'(req_payload.cell_index);
      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff;
         end
         ST_IDLE: begin
            ram_wr_en   = accept && (req_payload.cmd == CMD_WRITE) && !newline;
            ram_wr_data = {req_payload.attr, req_payload.char_code};
            ram_rd_en   = accept && (req_payload.cmd == CMD_READ);
         end
         ST_WRITE: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {attr_ff, 8'h00};
         end
         ST_SCROLL, ST_DRAIN: begin
            // read runs one row ahead; the write lands in the cycle after its read
            ram_wr_en   = wpend_ff;
            ram_wr_addr = wr_addr_ff;
            ram_wr_data = wr_zero_ff ? 16'h0000 : ram_rd_data;
            ram_rd_en   = (state_ff == ST_SCROLL) && (cnt_ff < AW'(CELLS - COLUMNS));
            ram_rd_addr = cnt_ff + AW'(COLUMNS);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      attr_in        = attr_ff;
      rd_hit_in      = rd_hit_ff;
      wpend_in       = 1'b0;
      wr_addr_in     = cnt_ff;
      wr_zero_in     = cnt_ff >= AW'(CELLS - COLUMNS);
      rsp_strobe_in  = 1'b0;
      rsp_payload_in = rsp_payload_ff;
      case (state_ff)
         ST_INIT: begin
            if (cnt_ff == AW'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               rd_hit_in = 1'b0;
               state_in  = ST_RESP;
               case (req_payload.cmd)
                  CMD_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     cnt_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  CMD_WRITE: begin
                     if (newline || (col_ff == CW'(COLUMNS - 1))) begin
                        col_in = '0;
                        if (row_ff == RW'(ROWS - 1)) begin
                           cnt_in   = '0;
                           state_in = ST_SCROLL;
                        end else begin
                           row_in = row_ff + 1'b1;
                        end
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
                  CMD_DELETE: begin
                     attr_in = req_payload.attr;
                     if (col_ff != '0) begin
                        col_in   = col_ff - 1'b1;
                        state_in = ST_WRITE;
                     end else if (row_ff != '0) begin
                        row_in   = row_ff - 1'b1;
                        col_in   = CW'(COLUMNS - 1);
                        state_in = ST_WRITE;
                     end
                  end
                  CMD_READ: begin
                     rd_hit_in = 32'(req_payload.cell_index) < CELLS;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            if (cnt_ff == AW'(CELLS - 1)) begin
               state_in = ST_RESP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            state_in = ST_RESP;
         end
         ST_SCROLL: begin
            wpend_in = 1'b1;
            if (cnt_ff == AW'(CELLS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_strobe_in             = 1'b1;
            rsp_payload_in.cursor_pos = 11'(cur_pos);
            rsp_payload_in.cell_char  = rd_hit_ff ? ram_rd_data[7:0] : 8'h00;
            rsp_payload_in.cell_attr  = rd_hit_ff ? ram_rd_data[15:8] : 8'h00;
            state_in                  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         cnt_ff        <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         wpend_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         wpend_ff      <= wpend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      attr_ff        <= attr_in;
      rd_hit_ff      <= rd_hit_in;
      wr_addr_ff     <= wr_addr_in;
      wr_zero_ff     <= wr_zero_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== design/tcw_checker.sv =====
`timescale 1ns / 1ps

module tcw_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input tcw_pkg::req_type req_payload,
   input logic             rsp_strobe,
   input tcw_pkg::rsp_type rsp_payload
);

   import tcw_pkg::*;

   // screen RAM is zeroed after reset before any transaction is taken
   a_init_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("not busy after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while still busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in consecutive cycles");

   a_cell_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.cmd != CMD_READ) |=> ##1
      (!rsp_strobe || (rsp_payload.cell_char == 8'h00 && rsp_payload.cell_attr == 8'h00)))
      else $error("cell fields nonzero for a non-read transaction");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);
